### design/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants for the Mandelbrot escape-time block.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int unsigned IN_FRAC = 28;  // fraction bits of c at the ports
  localparam int unsigned COORD_W = 32;  // width of c_real / c_imag
  localparam int unsigned COUNT_W = 9;   // width of iteration count and ceiling

  localparam logic [COUNT_W-1:0] CEIL_LIMIT = COUNT_W'(256);
  localparam logic [COUNT_W-1:0] CEIL_MIN   = COUNT_W'(1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MUL   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_TEST  = 4'b1000
  } state_t;

  // product selected for the shared multiplier
  typedef enum logic [1:0] {
    OP_RR = 2'd0,
    OP_II = 2'd1,
    OP_RI = 2'd2
  } op_t;

endpackage

### design/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Fixed-point escape-time count for one complex point c.
// ----------------------------------------------------------------------------
// Usage: drive in_c_real / in_c_imag (signed Q3.28) and raise start; the point
// is taken at the edge where start is high and busy is low. busy stays high
// while the point iterates z = z*z + c. The count (1..ceiling) appears on
// out_iteration_count for exactly one cycle with out_valid; the receiver
// cannot stall, so it must sample it then. A new point may be started in the
// cycle the result is strobed.
// All three products of an iteration go through one shared unsigned multiplier
// that takes ND*ND digit products per full product (ND = 1 while
// FRAC_BITS <= 31, 2 up to 63, ceil((FRAC_BITS+1)/32) in general). An
// iteration runs the products in ST_MUL, then ST_DRAIN and ST_TEST. A point
// that stops on the ceiling or on |zr|,|zi| >= 2 after n iterations is
// strobed after n product passes; one that stops on |z|^2 >= 4 needs one more
// product pass.
// cfg_wr_data sets the iteration ceiling (0 acts as 1, above 256 as 256);
// write it only while busy is low. Reset sets the ceiling to 256 and idles.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [mbe_pkg::COORD_W-1:0] in_c_real,
  input  logic signed [mbe_pkg::COORD_W-1:0] in_c_imag,
  output logic                              out_valid,
  output logic        [mbe_pkg::COUNT_W-1:0] out_iteration_count,
  input  logic                              cfg_wr_en,
  input  logic        [mbe_pkg::COUNT_W-1:0] cfg_wr_data
);

  localparam int unsigned CW   = mbe_pkg::COUNT_W;
  localparam int unsigned ZW   = FRAC_BITS + 5;            // |z| < 16 after update
  localparam int unsigned MAGW = FRAC_BITS + 1;            // |z| < 2 when multiplied
  localparam int unsigned ND   = (MAGW + 31) / 32;         // digits per operand
  localparam int unsigned DW   = (MAGW + ND - 1) / ND;     // digit width
  localparam int unsigned PW   = ND * DW;                  // padded operand width
  localparam int unsigned AW   = 2 * MAGW;                 // product width
  localparam int unsigned NK   = ND * ND;                  // digit products per product
  localparam int unsigned KW   = (NK > 1) ? $clog2(NK) : 1;
  localparam int unsigned SHW  = $clog2(2 * PW);
  localparam int unsigned SW   = FRAC_BITS + 3;            // sum of two squares
  localparam int unsigned SL   = (FRAC_BITS >= mbe_pkg::IN_FRAC) ?
                                 FRAC_BITS - mbe_pkg::IN_FRAC : 0;
  localparam int unsigned SR   = (FRAC_BITS >= mbe_pkg::IN_FRAC) ?
                                 0 : mbe_pkg::IN_FRAC - FRAC_BITS;

  localparam logic signed [ZW-1:0] TWO_FX     = ZW'(2) << FRAC_BITS;
  localparam logic signed [ZW-1:0] NEG_TWO_FX = -TWO_FX;

  mbe_pkg::state_t state_r, state_nxt;
  mbe_pkg::op_t    op_r, op_nxt;
  logic [KW-1:0]   k_r, k_nxt;

  logic [CW-1:0]   ceil_r;
  logic [CW-1:0]   lim_r, lim_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic signed [ZW-1:0] cr_r, cr_nxt, ci_r, ci_nxt;
  logic signed [ZW-1:0] zr_r, zr_nxt, zi_r, zi_nxt;

  logic [2*DW-1:0] prod_r, prod_nxt;
  logic [SHW-1:0]  pshift_r, pshift_nxt;
  mbe_pkg::op_t    pop_r, pop_nxt;
  logic            pvalid_r, pvalid_nxt;
  logic [AW-1:0]   acc_rr_r, acc_rr_nxt, acc_ii_r, acc_ii_nxt, acc_ri_r, acc_ri_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [CW-1:0]   out_count_r, out_count_nxt;

  // datapath intermediates
  logic signed [ZW-1:0] cr_in, ci_in;
  logic [MAGW-1:0]      mag_zr, mag_zi, opa, opb;
  logic [PW-1:0]        a_pad, b_pad;
  logic [KW-1:0]        di, dj;
  logic [DW-1:0]        dig_a, dig_b;
  logic [AW-1:0]        addend;
  logic [FRAC_BITS+1:0] sq_r, sq_i, q_ri;
  logic [SW-1:0]        sq_sum;
  logic                 neg_ri, inex_ri, sum_esc, bound_esc;
  logic signed [SW-1:0] cross_ri;
  logic signed [ZW-1:0] zr_upd, zi_upd;
  logic [CW-1:0]        count_inc, lim_eff;
  logic                 accept;

  // c moved to FRAC_BITS fraction bits, floor when bits are dropped
  generate
    if (FRAC_BITS >= mbe_pkg::IN_FRAC) begin : g_cvt_up
      assign cr_in = ZW'(in_c_real) <<< SL;
      assign ci_in = ZW'(in_c_imag) <<< SL;
    end else begin : g_cvt_dn
      assign cr_in = ZW'(in_c_real >>> SR);
      assign ci_in = ZW'(in_c_imag >>> SR);
    end
  endgenerate

  assign accept = start && (state_r == mbe_pkg::ST_IDLE);
  assign busy   = (state_r != mbe_pkg::ST_IDLE);

  always_comb begin
    if (ceil_r == '0) begin
      lim_eff = mbe_pkg::CEIL_MIN;
    end else if (ceil_r > mbe_pkg::CEIL_LIMIT) begin
      lim_eff = mbe_pkg::CEIL_LIMIT;
    end else begin
      lim_eff = ceil_r;
    end
  end

  // operand selection and digit split for the shared multiplier
  assign mag_zr = MAGW'(zr_r[ZW-1] ? -zr_r : zr_r);
  assign mag_zi = MAGW'(zi_r[ZW-1] ? -zi_r : zi_r);

  always_comb begin
    case (op_r)
      mbe_pkg::OP_RR: begin
        opa = mag_zr;
        opb = mag_zr;
      end
      mbe_pkg::OP_II: begin
        opa = mag_zi;
        opb = mag_zi;
      end
      mbe_pkg::OP_RI: begin
        opa = mag_zr;
        opb = mag_zi;
      end
      default: begin
        opa = mag_zr;
        opb = mag_zr;
      end
    endcase
  end

  assign a_pad = PW'(opa);
  assign b_pad = PW'(opb);
  assign di    = KW'(k_r / ND);
  assign dj    = KW'(k_r % ND);
  assign dig_a = a_pad[di*DW +: DW];
  assign dig_b = b_pad[dj*DW +: DW];

  // partial product placed at its digit weight; the full sum fits in AW bits
  assign addend = AW'((2*PW)'(prod_r) << pshift_r);

  // squares are floor = truncation; cross product floors toward minus infinity
  assign sq_r    = acc_rr_r[AW-1:FRAC_BITS];
  assign sq_i    = acc_ii_r[AW-1:FRAC_BITS];
  assign q_ri    = acc_ri_r[AW-1:FRAC_BITS];
  assign inex_ri = |acc_ri_r[FRAC_BITS-1:0];
  assign neg_ri  = zr_r[ZW-1] ^ zi_r[ZW-1];
  assign sq_sum  = SW'(sq_r) + SW'(sq_i);
  assign sum_esc = sq_sum[SW-1];  // sum < 8, so top bit set means >= 4
  assign cross_ri = ({1'b0, q_ri} ^ {SW{neg_ri}}) + SW'(neg_ri & !inex_ri);

  assign zr_upd    = ZW'(sq_r) - ZW'(sq_i) + cr_r;
  assign zi_upd    = (ZW'(cross_ri) <<< 1) + ci_r;
  assign bound_esc = (zr_upd >= TWO_FX) || (zr_upd <= NEG_TWO_FX) ||
                     (zi_upd >= TWO_FX) || (zi_upd <= NEG_TWO_FX);
  assign count_inc = count_r + CW'(1);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    k_nxt         = k_r;
    lim_nxt       = lim_r;
    count_nxt     = count_r;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    prod_nxt      = dig_a * dig_b;
    pshift_nxt    = SHW'(DW * (di + dj));
    pop_nxt       = op_r;
    pvalid_nxt    = (state_r == mbe_pkg::ST_MUL);
    acc_rr_nxt    = acc_rr_r;
    acc_ii_nxt    = acc_ii_r;
    acc_ri_nxt    = acc_ri_r;
    out_valid_nxt = 1'b0;
    out_count_nxt = out_count_r;

    if (pvalid_r) begin
      case (pop_r)
        mbe_pkg::OP_RR: acc_rr_nxt = acc_rr_r + addend;
        mbe_pkg::OP_II: acc_ii_nxt = acc_ii_r + addend;
        mbe_pkg::OP_RI: acc_ri_nxt = acc_ri_r + addend;
        default:        acc_rr_nxt = acc_rr_r;
      endcase
    end

    case (state_r)
      mbe_pkg::ST_IDLE: begin
        if (accept) begin
          cr_nxt     = cr_in;
          ci_nxt     = ci_in;
          zr_nxt     = '0;
          zi_nxt     = '0;
          count_nxt  = '0;
          lim_nxt    = lim_eff;
          op_nxt     = mbe_pkg::OP_RR;
          k_nxt      = '0;
          acc_rr_nxt = '0;
          acc_ii_nxt = '0;
          acc_ri_nxt = '0;
          state_nxt  = mbe_pkg::ST_MUL;
        end
      end
      mbe_pkg::ST_MUL: begin
        if (k_r == KW'(NK - 1)) begin
          k_nxt = '0;
          case (op_r)
            mbe_pkg::OP_RR: op_nxt = mbe_pkg::OP_II;
            mbe_pkg::OP_II: op_nxt = mbe_pkg::OP_RI;
            default:        state_nxt = mbe_pkg::ST_DRAIN;
          endcase
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      mbe_pkg::ST_DRAIN: begin
        state_nxt = mbe_pkg::ST_TEST;
      end
      mbe_pkg::ST_TEST: begin
        // squares of the current z give the |z|^2 test for the last iteration
        if (sum_esc) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          state_nxt     = mbe_pkg::ST_IDLE;
        end else begin
          zr_nxt    = zr_upd;
          zi_nxt    = zi_upd;
          count_nxt = count_inc;
          if (bound_esc || (count_inc == lim_r)) begin
            out_valid_nxt = 1'b1;
            out_count_nxt = count_inc;
            state_nxt     = mbe_pkg::ST_IDLE;
          end else begin
            op_nxt     = mbe_pkg::OP_RR;
            k_nxt      = '0;
            acc_rr_nxt = '0;
            acc_ii_nxt = '0;
            acc_ri_nxt = '0;
            state_nxt  = mbe_pkg::ST_MUL;
          end
        end
      end
      default: begin
        state_nxt = mbe_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbe_pkg::ST_IDLE;
      op_r        <= mbe_pkg::OP_RR;
      k_r         <= '0;
      pvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
      ceil_r      <= mbe_pkg::CEIL_LIMIT;
      count_r     <= '0;
      lim_r       <= mbe_pkg::CEIL_LIMIT;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      k_r         <= k_nxt;
      pvalid_r    <= pvalid_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      lim_r       <= lim_nxt;
      if (cfg_wr_en) begin
        ceil_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cr_r        <= cr_nxt;
    ci_r        <= ci_nxt;
    zr_r        <= zr_nxt;
    zi_r        <= zi_nxt;
    prod_r      <= prod_nxt;
    pshift_r    <= pshift_nxt;
    pop_r       <= pop_nxt;
    acc_rr_r    <= acc_rr_nxt;
    acc_ii_r    <= acc_ii_nxt;
    acc_ri_r    <= acc_ri_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_count_r;

  // a result only follows a cycle in which a point was being worked on
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == mbe_pkg::ST_TEST))
    else $error("result strobe without a finished point");

  // the count never reaches the ceiling while iterating
  a_count_below_lim: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (count_r < lim_r))
    else $error("iteration count at or past ceiling while busy");

  // an accepted point starts the product pass
  a_start_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == mbe_pkg::ST_MUL))
    else $error("accepted point did not start the multiplier");

  // reported count is within 1..ceiling
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_iteration_count != '0) &&
                   (out_iteration_count <= lim_r)))
    else $error("reported count out of range");

  // no partial product outstanding once the test step runs
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mbe_pkg::ST_TEST) |-> !pvalid_r)
    else $error("test step with a partial product still in flight");

endmodule
